// ----- hw/rtl/isu_pkg.sv -----
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and constants of the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
package isu_pkg;

  localparam int DEF_LATTICE_SIDE = 64;
  localparam int COORD_W          = 6;
  localparam int FRAC_W           = 32;
  localparam int LIMIT_W          = 33;
  localparam int TOTAL_W          = 14;
  localparam int NUM_LIMITS       = 8;
  localparam int LIMIT_IDX_W      = 3;
  localparam int K_W              = 4;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_NEVER  = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_ALWAYS = {1'b1, {FRAC_W{1'b0}}};

  // first half of the limit set serves positive k, second half negative k
  localparam int NUM_POS_LIMITS = NUM_LIMITS / 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_UP,
    ST_RD_DN,
    ST_EXEC
  } state_e;

endpackage

// ----- hw/rtl/ising_metropolis_site_update.sv -----
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis spin update and spin load on a square Ising lattice with open
// boundaries, with running magnetization and bond energy.
// ----------------------------------------------------------------------------
// Words are taken one at a time: the lattice sits in one RAM with one row per
// entry and one read port, and a word needs three row reads (its own row and
// the rows above and below) before the flip decision and write-back. Rows
// never written since reset read as all spins up through per-row valid bits,
// so there is no clearing pass after reset. A finished result waits in the
// output register while the next word is taken in. The magnetization and
// energy outputs wrap modulo 2^14.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update #(
  parameter int LatticeSide = isu_pkg::DEF_LATTICE_SIDE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [isu_pkg::LIMIT_IDX_W-1:0]   cfg_idx_i,
  input  logic [isu_pkg::LIMIT_W-1:0]       cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [isu_pkg::COORD_W-1:0]       row_i,
  input  logic [isu_pkg::COORD_W-1:0]       column_i,
  input  logic                              load_spin_i,
  input  logic [isu_pkg::FRAC_W-1:0]        random_fraction_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              flipped_o,
  output logic                              site_spin_o,
  output logic signed [isu_pkg::TOTAL_W-1:0] magnetization_o,
  output logic signed [isu_pkg::TOTAL_W-1:0] energy_o
);

  localparam int AW = $clog2(LatticeSide);
  localparam int TW = isu_pkg::TOTAL_W;
  localparam int KW = isu_pkg::K_W;
  localparam int LW = isu_pkg::LIMIT_W;
  localparam int SW = isu_pkg::LIMIT_IDX_W;
  localparam logic signed [TW-1:0] MagRst = TW'(LatticeSide * LatticeSide);
  localparam logic signed [TW-1:0] EngRst = TW'(-2 * LatticeSide * (LatticeSide - 1));

  isu_pkg::state_e state_q, state_d;

  logic                          op_q, lspin_q;
  logic [isu_pkg::COORD_W-1:0]   row_q, col_q;
  logic [isu_pkg::FRAC_W-1:0]    rnd_q;

  logic [LatticeSide-1:0] mid_q, up_q;
  logic [LatticeSide-1:0] vld_q;
  logic                   rd_vld_q, rd_vld_d;
  logic [LW-1:0]          lim_q [isu_pkg::NUM_LIMITS];

  logic signed [TW-1:0] mag_q, mag_d, eng_q, eng_d;
  logic                 out_valid_q, flipped_q, spin_q;

  logic                   in_acc, re, mid_cap, up_cap, exec_go;
  logic [AW-1:0]          raddr, row_addr, col_idx;
  logic [LatticeSide-1:0] rdata, row_eff, wrow;

  logic                 in_range, has_up, has_dn, has_lf, has_rt;
  logic                 old_bit, new_bit, rand_hit, do_flip;
  logic signed [KW-1:0] nsum, k;
  logic [SW-1:0]        sel;

  // -------------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isu_pkg::ST_IDLE:  if (in_valid_i) state_d = isu_pkg::ST_RD_UP;
      isu_pkg::ST_RD_UP: state_d = isu_pkg::ST_RD_DN;
      isu_pkg::ST_RD_DN: state_d = isu_pkg::ST_EXEC;
      isu_pkg::ST_EXEC:  if (!out_valid_q || out_ready_i) state_d = isu_pkg::ST_IDLE;
      default:           state_d = isu_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    re         = 1'b0;
    mid_cap    = 1'b0;
    up_cap     = 1'b0;
    exec_go    = 1'b0;
    raddr      = row_addr;
    case (state_q)
      isu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        re         = 1'b1;
        raddr      = AW'(row_i);
      end
      isu_pkg::ST_RD_UP: begin
        re      = 1'b1;
        mid_cap = 1'b1;
        raddr   = row_addr - AW'(1);
      end
      isu_pkg::ST_RD_DN: begin
        re     = 1'b1;
        up_cap = 1'b1;
        raddr  = row_addr + AW'(1);
      end
      isu_pkg::ST_EXEC: begin
        exec_go = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign in_acc   = in_valid_i && in_ready_o;
  assign row_addr = AW'(row_q);
  assign col_idx  = AW'(col_q);

  // -------------------------------------------------------------------------
  // lattice rows
  isu_ram #(
    .Width (LatticeSide),
    .Depth (LatticeSide)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (exec_go && do_flip),
    .waddr_i (row_addr),
    .wdata_i (wrow),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_vld_d = (32'(raddr) < 32'(LatticeSide)) ? vld_q[raddr] : 1'b1;
  assign row_eff  = rd_vld_q ? rdata : '1;

  // -------------------------------------------------------------------------
  // flip decision
  assign in_range = (32'(row_q) < 32'(LatticeSide)) && (32'(col_q) < 32'(LatticeSide));
  assign has_up   = (row_q != '0);
  assign has_dn   = (32'(row_q) < 32'(LatticeSide - 1));
  assign has_lf   = (col_q != '0);
  assign has_rt   = (32'(col_q) < 32'(LatticeSide - 1));
  assign old_bit  = mid_q[col_idx];

  always_comb begin
    nsum = '0;
    if (has_up) nsum = up_q[col_idx] ? nsum + KW'(1) : nsum - KW'(1);
    if (has_dn) nsum = row_eff[col_idx] ? nsum + KW'(1) : nsum - KW'(1);
    if (has_lf) nsum = mid_q[col_idx - AW'(1)] ? nsum + KW'(1) : nsum - KW'(1);
    if (has_rt) nsum = mid_q[col_idx + AW'(1)] ? nsum + KW'(1) : nsum - KW'(1);
  end

  assign k        = old_bit ? nsum : -nsum;
  assign sel      = k[KW-1] ? SW'(KW'(isu_pkg::NUM_POS_LIMITS - 1) - k) : SW'(k - KW'(1));
  assign rand_hit = {1'b0, rnd_q} < lim_q[sel];

  always_comb begin
    do_flip = 1'b0;
    if (in_range) begin
      if (op_q == isu_pkg::OP_LOAD) begin
        do_flip = (old_bit != lspin_q);
      end else begin
        do_flip = (k == '0) || rand_hit;
      end
    end
  end

  assign new_bit = old_bit ^ do_flip;

  always_comb begin
    wrow          = mid_q;
    wrow[col_idx] = new_bit;
  end

  assign mag_d = old_bit ? mag_q - TW'(2) : mag_q + TW'(2);
  assign eng_d = eng_q + {{(TW - KW - 1){k[KW-1]}}, k, 1'b0};

  // -------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      mag_q       <= MagRst;
      eng_q       <= EngRst;
      for (int i = 0; i < isu_pkg::NUM_LIMITS; i++) begin
        lim_q[i] <= (i < isu_pkg::NUM_POS_LIMITS) ? isu_pkg::LIMIT_NEVER
                                                  : isu_pkg::LIMIT_ALWAYS;
      end
    end else begin
      state_q <= state_d;
      if (re) rd_vld_q <= rd_vld_d;
      if (cfg_we_i) lim_q[cfg_idx_i] <= cfg_data_i;
      if (exec_go) begin
        out_valid_q <= 1'b1;
        if (do_flip) begin
          vld_q[row_addr] <= 1'b1;
          mag_q           <= mag_d;
          eng_q           <= eng_d;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: hold the word, its own row, the row above it and the result flags
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      row_q   <= row_i;
      col_q   <= column_i;
      lspin_q <= load_spin_i;
      rnd_q   <= random_fraction_i;
    end
    if (mid_cap) mid_q <= row_eff;
    if (up_cap)  up_q  <= row_eff;
    if (exec_go) begin
      flipped_q <= do_flip;
      spin_q    <= in_range && new_bit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign flipped_o       = flipped_q;
  assign site_spin_o     = spin_q;
  assign magnetization_o = mag_q;
  assign energy_o        = eng_q;

endmodule

// ----- hw/rtl/isu_ram.sv -----
// ----------------------------------------------------------------------------
// isu_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module isu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
